### src/http_header_length_scanner_assert.svh
// Assertion macros used by the checker file.
`ifndef HTTP_HEADER_LENGTH_SCANNER_ASSERT_SVH
`define HTTP_HEADER_LENGTH_SCANNER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define HHLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define HHLS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### src/hhls_pkg.sv
package hhls_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 21;
  localparam int unsigned VALUE_W  = 31;
  localparam int unsigned KEY_LEN  = 16;
  localparam int unsigned KEY_IDX_W = $clog2(KEY_LEN);

  // Byte count stops here
  localparam logic [POS_W-1:0] MAX_BYTES = POS_W'(1048576);
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;

  // Progress through CR LF CR LF
  typedef enum logic [1:0] {
    CRLF_NONE = 2'd0,
    CRLF_CR1  = 2'd1,
    CRLF_LF1  = 2'd2,
    CRLF_CR2  = 2'd3
  } crlf_e;

  // Length header parse phase
  typedef enum logic [1:0] {
    PH_SEARCHING = 2'd0,
    PH_DIGITS    = 2'd1,
    PH_DONE      = 2'd2
  } phase_e;

  // Input register contents
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } stage_t;

  // One result item
  typedef struct packed {
    logic               header_end_found;
    logic [POS_W-1:0]   data_start;
    logic               length_found;
    logic [VALUE_W-1:0] content_length;
    logic               length_saturated;
  } res_t;

  // "Content-Length: " one character per index
  function automatic logic [BYTE_W-1:0] key_char(input logic [KEY_IDX_W-1:0] idx);
    logic [BYTE_W-1:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h43; // C
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h4C; // L
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      4'd14:   ch = 8'h3A; // :
      default: ch = 8'h20; // space
    endcase
    return ch;
  endfunction

endpackage

### src/hhls_in_if.sv
interface hhls_in_if
  import hhls_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### src/hhls_out_if.sv
interface hhls_out_if
  import hhls_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               header_end_found;
  logic [POS_W-1:0]   data_start;
  logic               length_found;
  logic [VALUE_W-1:0] content_length;
  logic               length_saturated;

  modport source (output valid, output header_end_found, output data_start,
                  output length_found, output content_length, output length_saturated,
                  input ready);
  modport sink   (input valid, input header_end_found, input data_start,
                  input length_found, input content_length, input length_saturated,
                  output ready);
endinterface

### src/hhls_in_stage.sv
module hhls_in_stage
  import hhls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  hhls_in_if.sink     in_i,
  input  logic        adv_i,
  output stage_t      stage_o
);

  logic              valid_q;
  logic [BYTE_W-1:0] byte_q;
  logic              last_q;
  logic              take;

  // Room when empty or when the held byte moves on this cycle
  assign in_i.ready = !valid_q || adv_i;
  assign take       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (adv_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= in_i.data_byte;
      last_q <= in_i.last_byte;
    end
  end

  assign stage_o.valid     = valid_q;
  assign stage_o.data_byte = byte_q;
  assign stage_o.last_byte = last_q;

endmodule

### src/hhls_scan_core.sv
module hhls_scan_core
  import hhls_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  stage_t stage_i,
  input  logic   adv_i,
  output res_t   res_o
);

  crlf_e                crlf_q, crlf_d, crlf_n;
  logic [KEY_IDX_W-1:0] pat_q, pat_d, pat_n;
  logic [POS_W-1:0]     pos_q, pos_d, pos_n;
  logic [POS_W-1:0]     body_q, body_d, body_n;
  logic                 seen_q, seen_d, seen_n;
  phase_e               phase_q, phase_d, phase_n;
  logic [VALUE_W-1:0]   acc_q, acc_d, acc_n;
  logic                 ovf_q, ovf_d, ovf_n;

  logic [BYTE_W-1:0]    b;
  logic                 is_cr, is_lf, is_digit;
  logic [3:0]           digit;
  logic [VALUE_W+3:0]   prod;

  assign b        = stage_i.data_byte;
  assign is_cr    = (b == CH_CR);
  assign is_lf    = (b == CH_LF);
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign digit    = 4'(b - CH_ZERO);
  // acc * 10 + digit
  assign prod = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + (VALUE_W+4)'(digit);

  // Next state for the byte in the input register
  always_comb begin
    pos_n   = (pos_q != MAX_BYTES) ? pos_q + POS_W'(1) : pos_q;
    body_n  = body_q;
    seen_n  = seen_q;
    crlf_n  = CRLF_NONE;
    pat_n   = pat_q;
    phase_n = phase_q;
    acc_n   = acc_q;
    ovf_n   = ovf_q;

    // Blank line detector, overlapping matches allowed
    case (crlf_q)
      CRLF_NONE: crlf_n = is_cr ? CRLF_CR1 : CRLF_NONE;
      CRLF_CR1:  crlf_n = is_lf ? CRLF_LF1 : (is_cr ? CRLF_CR1 : CRLF_NONE);
      CRLF_LF1:  crlf_n = is_cr ? CRLF_CR2 : CRLF_NONE;
      default: begin
        if (is_lf) begin
          seen_n = 1'b1;
          body_n = pos_n;
          crlf_n = CRLF_LF1;
        end else begin
          crlf_n = is_cr ? CRLF_CR1 : CRLF_NONE;
        end
      end
    endcase

    // Header key match, then decimal value
    case (phase_q)
      PH_SEARCHING: begin
        if (b == key_char(pat_q)) begin
          if (pat_q == KEY_IDX_W'(KEY_LEN - 1)) begin
            phase_n = PH_DIGITS;
            pat_n   = '0;
          end else begin
            pat_n = pat_q + KEY_IDX_W'(1);
          end
        end else begin
          pat_n = (b == key_char('0)) ? KEY_IDX_W'(1) : '0;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          if (ovf_q || (|prod[VALUE_W+3:VALUE_W])) begin
            acc_n = VALUE_MAX;
            ovf_n = 1'b1;
          end else begin
            acc_n = prod[VALUE_W-1:0];
          end
        end else begin
          phase_n = PH_DONE;
        end
      end
      default: ;
    endcase
  end

  // Result from the updated state
  always_comb begin
    res_o.header_end_found = seen_n;
    res_o.data_start       = seen_n ? body_n : '0;
    res_o.length_found     = (phase_n != PH_SEARCHING);
    res_o.content_length   = (phase_n != PH_SEARCHING) ? acc_n : '0;
    res_o.length_saturated = (phase_n != PH_SEARCHING) && ovf_n;
  end

  // Last byte of a buffer returns everything to reset
  always_comb begin
    if (stage_i.last_byte) begin
      crlf_d  = CRLF_NONE;
      pat_d   = '0;
      pos_d   = '0;
      body_d  = '0;
      seen_d  = 1'b0;
      phase_d = PH_SEARCHING;
      acc_d   = '0;
      ovf_d   = 1'b0;
    end else begin
      crlf_d  = crlf_n;
      pat_d   = pat_n;
      pos_d   = pos_n;
      body_d  = body_n;
      seen_d  = seen_n;
      phase_d = phase_n;
      acc_d   = acc_n;
      ovf_d   = ovf_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crlf_q  <= CRLF_NONE;
      pat_q   <= '0;
      pos_q   <= '0;
      body_q  <= '0;
      seen_q  <= 1'b0;
      phase_q <= PH_SEARCHING;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (adv_i) begin
      crlf_q  <= crlf_d;
      pat_q   <= pat_d;
      pos_q   <= pos_d;
      body_q  <= body_d;
      seen_q  <= seen_d;
      phase_q <= phase_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

### src/hhls_out_stage.sv
module hhls_out_stage
  import hhls_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  res_t       res_i,
  output logic       free_o,
  hhls_out_if.source out_o
);

  logic valid_q;
  res_t res_q;

  // Can take a result when empty or when the held one leaves now
  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.header_end_found = res_q.header_end_found;
  assign out_o.data_start       = res_q.data_start;
  assign out_o.length_found     = res_q.length_found;
  assign out_o.content_length   = res_q.content_length;
  assign out_o.length_saturated = res_q.length_saturated;

endmodule

### src/http_header_length_scanner.sv
// Request header scanner. Takes one byte of a received request per cycle on
// in_i and, on the byte marked last_byte, hands one result transfer to out_o:
// the byte count through the last CR LF CR LF (where the body starts) and
// the decimal value after the first "Content-Length: ", saturating at
// 2^31-1 with a flag; fields read zero when their pattern was not seen.
// Throughput is one byte per cycle: a byte passes an input register and
// the combinational match and accumulate logic, and the result of a last
// byte lands in the result register before it shows on out_o.
// Input stalls only while a last byte waits behind a result that out_o has
// not taken yet. After each buffer all scan state returns to its reset value.
module http_header_length_scanner
  import hhls_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  hhls_in_if.sink    in_i,
  hhls_out_if.source out_o
);

  stage_t stage;
  res_t   res;
  logic   out_free;
  logic   adv;

  // Non-last bytes never wait; a last byte needs room for its result
  assign adv = stage.valid && (!stage.last_byte || out_free);

  hhls_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .stage_o (stage)
  );

  hhls_scan_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .adv_i   (adv),
    .res_o   (res)
  );

  hhls_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (adv && stage.last_byte),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule

### src/hhls_checker.sv
`include "http_header_length_scanner_assert.svh"

module hhls_checker
  import hhls_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               header_end_found_i,
  input logic [POS_W-1:0]   data_start_i,
  input logic               length_found_i,
  input logic [VALUE_W-1:0] content_length_i,
  input logic               length_saturated_i
);

  // Result held until taken
  `HHLS_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")
  `HHLS_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(data_start_i) && $stable(content_length_i) && $stable(length_saturated_i), "stalled result changed")

  // Fields zero when their pattern was absent
  `HHLS_ASSERT(a_no_end, out_valid_i && !header_end_found_i |-> data_start_i == '0, "data_start without header end")
  `HHLS_ASSERT(a_no_len, out_valid_i && !length_found_i |-> content_length_i == '0 && !length_saturated_i, "length without match")

  // Saturation pins the value at its maximum
  `HHLS_ASSERT(a_sat_max, out_valid_i && length_saturated_i |-> content_length_i == VALUE_MAX, "saturated value not at maximum")

endmodule

bind http_header_length_scanner hhls_checker u_hhls_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .header_end_found_i (out_o.header_end_found),
  .data_start_i       (out_o.data_start),
  .length_found_i     (out_o.length_found),
  .content_length_i   (out_o.content_length),
  .length_saturated_i (out_o.length_saturated)
);
